// File: src/nfsp_pkg.sv
// Types and character codes shared by the numeric format spec parser.
`timescale 1ns / 1ps
`default_nettype none
package nfsp_pkg;

	localparam int VALUE_BITS_DEF = 8;

	typedef enum logic [1:0] {
		PH_FLAGS,
		PH_NUM,
		PH_DONE
	} phase_t;

	typedef enum logic [2:0] {
		SF_NONE,
		SF_WIDTH,
		SF_WSTAR,
		SF_SIG,
		SF_LEFT,
		SF_EXP,
		SF_POINT,
		SF_SWITCH
	} subfield_t;

	typedef enum logic [2:0] {
		ST_OK,
		ST_BAD_FILL,
		ST_PREMATURE_END,
		ST_BAD_SUBFIELD,
		ST_MISPLACED_WIDTH,
		ST_BAD_TYPE
	} status_t;

	typedef struct packed {
		phase_t    phase;
		subfield_t sf;
		logic      fill_pending;
		logic      numeric_first;
		logic      dcn;
		logic      exp_head;
	} ctrl_t;

	localparam ctrl_t CTRL_RESET = '{
		phase: PH_FLAGS,
		sf: SF_NONE,
		fill_pending: 1'b0,
		numeric_first: 1'b1,
		dcn: 1'b0,
		exp_head: 1'b0
	};

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BANG   = 8'h21;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_AMP    = 8'h26;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_SEMI   = 8'h3B;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_AT     = 8'h40;
	localparam logic [7:0] CH_UPPE   = 8'h45;
	localparam logic [7:0] CH_UPPG   = 8'h47;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LOWA   = 8'h61;
	localparam logic [7:0] CH_LOWE   = 8'h65;
	localparam logic [7:0] CH_LOWF   = 8'h66;
	localparam logic [7:0] CH_LOWG   = 8'h67;
	localparam logic [7:0] CH_LOWS   = 8'h73;
	localparam logic [7:0] CH_TILDE  = 8'h7E;

endpackage
`default_nettype wire

// File: src/nfsp_step.sv
// Next-state and status decode for one format-string character.
`timescale 1ns / 1ps
`default_nettype none
module nfsp_step
	import nfsp_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic [7:0]            ch,
	input  wire logic                  start_of_string,
	input  wire ctrl_t                 ctrl,
	input  wire logic [VALUE_BITS-1:0] accum,
	output ctrl_t                      ctrl_nxt,
	output logic [VALUE_BITS-1:0]      accum_nxt,
	output logic                       emit,
	output status_t                    status
);

	localparam int WW = VALUE_BITS + 4;
	localparam logic [WW-1:0] LIM = {4'b0000, {VALUE_BITS{1'b1}}};

	typedef struct packed {
		logic                  emit;
		status_t               st;
		subfield_t             sf;
		logic                  dcn;
		logic                  exp_head;
		logic [VALUE_BITS-1:0] acc;
	} top_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= CH_ZERO) && (c <= CH_NINE);
	endfunction

	function automatic logic [VALUE_BITS-1:0] sat_digit(input logic [VALUE_BITS-1:0] a,
		input logic [7:0] c);
		logic [WW-1:0] w;
		w = ({4'b0000, a} * WW'(10)) + WW'(c[3:0]);
		return (w > LIM) ? {VALUE_BITS{1'b1}} : w[VALUE_BITS-1:0];
	endfunction

	function automatic top_t top_fn(input logic [7:0] c, input logic first);
		top_t t;
		t.emit     = 1'b0;
		t.st       = ST_OK;
		t.sf       = SF_NONE;
		t.dcn      = 1'b0;
		t.exp_head = 1'b0;
		t.acc      = '0;
		if (is_digit(c) || (c == CH_STAR)) begin
			if (!first) begin
				t.emit = 1'b1;
				t.st   = ST_MISPLACED_WIDTH;
			end else if (is_digit(c)) begin
				t.sf  = SF_WIDTH;
				t.dcn = 1'b1;
				t.acc = VALUE_BITS'(c[3:0]);
			end else begin
				t.sf = SF_WSTAR;
			end
		end else begin
			unique case (c)
				CH_DOT: t.sf = SF_SIG;
				CH_SEMI: t.sf = SF_LEFT;
				CH_CARET: begin
					t.sf       = SF_EXP;
					t.exp_head = 1'b1;
				end
				CH_TILDE: t.sf = SF_POINT;
				CH_QUEST: t.sf = SF_SWITCH;
				CH_LOWF, CH_LOWG, CH_UPPG, CH_LOWE, CH_UPPE: t.emit = 1'b1;
				default: begin
					t.emit = 1'b1;
					t.st   = ST_BAD_TYPE;
				end
			endcase
		end
		return t;
	endfunction

	ctrl_t                 cur;
	logic [VALUE_BITS-1:0] acc_cur;
	logic                  use_top;
	logic                  head;
	top_t                  t;

	always_comb begin
		cur       = start_of_string ? CTRL_RESET : ctrl;
		acc_cur   = start_of_string ? '0 : accum;
		t         = top_fn(ch, cur.numeric_first);
		ctrl_nxt  = cur;
		accum_nxt = acc_cur;
		emit      = 1'b0;
		status    = ST_OK;
		use_top   = 1'b0;
		head      = (cur.sf == SF_EXP) && cur.exp_head;
		unique case (cur.phase)
			PH_FLAGS: begin
				if (cur.fill_pending) begin
					if ((ch < CH_SPACE) || (ch > CH_TILDE)) begin
						emit   = 1'b1;
						status = ST_BAD_FILL;
					end else begin
						ctrl_nxt.fill_pending = 1'b0;
					end
				end else begin
					unique case (ch)
						CH_PLUS, CH_MINUS, CH_HASH, CH_ZERO, CH_SPACE, CH_BANG,
						CH_COMMA, CH_AT: ;
						CH_AMP: ctrl_nxt.fill_pending = 1'b1;
						CH_NUL: begin
							emit   = 1'b1;
							status = ST_PREMATURE_END;
						end
						default: begin
							ctrl_nxt.phase = PH_NUM;
							use_top        = 1'b1;
						end
					endcase
				end
			end
			PH_NUM: begin
				if (cur.sf == SF_NONE) begin
					use_top = 1'b1;
				end else if (cur.sf == SF_WSTAR) begin
					ctrl_nxt.sf = SF_NONE;
					use_top     = (ch != CH_PLUS);
				end else begin
					if (head)
						ctrl_nxt.exp_head = 1'b0;
					priority if (head && ((ch == CH_LOWS) || (ch == CH_LOWA))) begin
					end else if (is_digit(ch)) begin
						accum_nxt    = sat_digit(acc_cur, ch);
						ctrl_nxt.dcn = 1'b1;
					end else if (ch == CH_STAR) begin
						if (cur.dcn) begin
							emit   = 1'b1;
							status = ST_BAD_SUBFIELD;
						end else begin
							ctrl_nxt.sf  = (cur.sf == SF_WIDTH) ? SF_WSTAR : SF_NONE;
							ctrl_nxt.dcn = 1'b0;
							accum_nxt    = '0;
						end
					end else if ((cur.sf == SF_LEFT) && ((ch == CH_PLUS) || (ch == CH_MINUS))) begin
						if (cur.dcn) begin
							emit   = 1'b1;
							status = ST_BAD_SUBFIELD;
						end else begin
							ctrl_nxt.dcn = 1'b1;
						end
					end else if ((cur.sf == SF_EXP) && (ch == CH_PLUS)) begin
						if (cur.dcn) begin
							emit   = 1'b1;
							status = ST_BAD_SUBFIELD;
						end
					end else if (ch == CH_NUL) begin
						emit   = 1'b1;
						status = ST_PREMATURE_END;
					end else begin
						use_top = 1'b1;
					end
				end
			end
			default: ;
		endcase
		if (use_top) begin
			ctrl_nxt.sf            = t.sf;
			ctrl_nxt.dcn           = t.dcn;
			ctrl_nxt.exp_head      = t.exp_head;
			ctrl_nxt.numeric_first = 1'b0;
			accum_nxt              = t.acc;
			emit                   = t.emit;
			status                 = t.st;
		end
		if (emit)
			ctrl_nxt.phase = PH_DONE;
	end

endmodule
`default_nettype wire

// File: src/numeric_format_spec_parser.sv
// Top level of the numeric format spec parser.
// Takes one character per cycle; the parse state updates at the accepting edge and a
// status, when the character ends the string or hits an error, lands in a one-deep
// output register visible the next cycle. The rate is one character per cycle;
// in_ready drops only while a status is held untaken.
// After a status, characters are dropped silently until start_of_string.
`timescale 1ns / 1ps
`default_nettype none
module numeric_format_spec_parser
	import nfsp_pkg::*;
#(
	parameter int VALUE_BITS = VALUE_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] ch,
	input  wire logic       start_of_string,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic [2:0]      status
);

	ctrl_t                 ctrl_q;
	ctrl_t                 ctrl_nxt;
	logic [VALUE_BITS-1:0] accum_q;
	logic [VALUE_BITS-1:0] accum_nxt;
	logic                  emit;
	status_t               st;
	logic                  out_valid_q;
	status_t               status_q;
	logic                  accept;

	nfsp_step #(
		.VALUE_BITS(VALUE_BITS)
	) u_step (
		.ch(ch),
		.start_of_string(start_of_string),
		.ctrl(ctrl_q),
		.accum(accum_q),
		.ctrl_nxt(ctrl_nxt),
		.accum_nxt(accum_nxt),
		.emit(emit),
		.status(st)
	);

	assign in_ready  = !out_valid_q || out_ready;
	assign accept    = in_valid && in_ready;
	assign out_valid = out_valid_q;
	assign status    = status_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q      <= CTRL_RESET;
			accum_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				ctrl_q  <= ctrl_nxt;
				accum_q <= accum_nxt;
			end
			if (accept && emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit)
			status_q <= st;
	end

endmodule
`default_nettype wire

// File: src/nfsp_checker.sv
// Port-level checks for the numeric format spec parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module nfsp_checker
	import nfsp_pkg::*;
(
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic [7:0] ch,
	input wire logic       start_of_string,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] status
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status))
		else $error("result transaction dropped or changed while stalled");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= ST_BAD_TYPE)
		else $error("status code out of range");

	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) == !in_ready)
		else $error("input ready does not follow output register occupancy");

	a_empty_string: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && start_of_string && (ch == CH_NUL)
		|=> out_valid && (status == ST_PREMATURE_END))
		else $error("empty string did not report premature end");

endmodule

bind numeric_format_spec_parser nfsp_checker u_nfsp_checker (.*);
`default_nettype wire

// File: tb/numeric_format_spec_parser_test.sv
// Self-checking testbench for the numeric format spec parser: directed and random strings.
`timescale 1ns / 1ps
module numeric_format_spec_parser_test;
	import nfsp_pkg::*;

	localparam int CLK_PERIOD = 8;
	localparam int STALL_LIMIT = 4000;
	localparam int DRAIN_CYCLES = 16;
	localparam int NO_STATUS = -1;
	localparam logic [7:0] CH_LOW_CTRL = 8'h1F;
	localparam logic [7:0] CH_DEL = 8'h7F;
	localparam logic [7:0] CH_TOP = 8'hFF;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       in_valid = 1'b0;
	logic       in_ready;
	logic [7:0] ch = 8'h00;
	logic       start_of_string = 1'b0;
	logic       out_valid;
	logic       out_ready = 1'b0;
	logic [2:0] status;

	phase_t      spec_phase;
	subfield_t   spec_field;
	logic        fill_pending;
	logic        numeric_first;
	logic        have_digits;
	logic        value_negative;
	logic        exp_head;
	logic [15:0] value_accum;

	logic [2:0]  expected_status_q[$];
	logic [7:0]  spec_chars[$];
	logic [2:0]  want_status;
	int unsigned tx_idle_pct = 20;
	int unsigned rx_idle_pct = 87;
	int          error_count = 0;
	int          stall_cycles = 0;
	int          parsed_chars = 0;

	numeric_format_spec_parser uut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.ch              (ch),
		.start_of_string (start_of_string),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.status          (status)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= CH_ZERO && c <= CH_NINE;
	endfunction

	function automatic void clear_value();
		value_accum = '0;
		value_negative = 1'b0;
		have_digits = 1'b0;
	endfunction

	function automatic void reset_parser();
		spec_phase = PH_FLAGS;
		spec_field = SF_NONE;
		fill_pending = 1'b0;
		numeric_first = 1'b1;
		exp_head = 1'b0;
		clear_value();
	endfunction

	function automatic int parse_char(input logic [7:0] c, input logic sos);
		int          r;
		logic        at_top;
		logic        busy;
		logic        first;
		logic        skip;
		logic [31:0] sum;
		logic [31:0] lim;
		r = NO_STATUS;
		at_top = 1'b0;
		busy = 1'b1;
		lim = (32'd1 << VALUE_BITS_DEF) - 32'd1;
		if (sos)
			reset_parser();
		if (spec_phase == PH_DONE)
			return NO_STATUS;
		if (spec_phase == PH_FLAGS) begin
			busy = 1'b0;
			if (fill_pending) begin
				if (c < CH_SPACE || c > CH_TILDE)
					r = ST_BAD_FILL;
				else
					fill_pending = 1'b0;
			end else begin
				case (c)
				CH_PLUS, CH_MINUS, CH_HASH, CH_ZERO, CH_SPACE, CH_BANG, CH_COMMA, CH_AT: begin
				end
				CH_AMP: fill_pending = 1'b1;
				CH_NUL: r = ST_PREMATURE_END;
				default: begin
					spec_phase = PH_NUM;
					at_top = 1'b1;
					busy = 1'b1;
				end
				endcase
			end
		end else begin
			at_top = (spec_field == SF_NONE);
		end
		while (busy) begin
			busy = 1'b0;
			if (at_top) begin
				first = numeric_first;
				numeric_first = 1'b0;
				clear_value();
				if (is_digit(c) || c == CH_STAR) begin
					if (!first) begin
						r = ST_MISPLACED_WIDTH;
					end else begin
						spec_field = SF_WIDTH;
						at_top = 1'b0;
						busy = 1'b1;
					end
				end else begin
					case (c)
					CH_DOT: spec_field = SF_SIG;
					CH_SEMI: spec_field = SF_LEFT;
					CH_CARET: begin
						spec_field = SF_EXP;
						exp_head = 1'b1;
					end
					CH_TILDE: spec_field = SF_POINT;
					CH_QUEST: spec_field = SF_SWITCH;
					CH_LOWF, CH_LOWG, CH_UPPG, CH_LOWE, CH_UPPE: r = ST_OK;
					default: r = ST_BAD_TYPE;
					endcase
				end
			end else if (spec_field == SF_WSTAR) begin
				spec_field = SF_NONE;
				if (c != CH_PLUS) begin
					at_top = 1'b1;
					busy = 1'b1;
				end
			end else begin
				skip = 1'b0;
				if (spec_field == SF_EXP && exp_head) begin
					exp_head = 1'b0;
					skip = (c == CH_LOWS || c == CH_LOWA);
				end
				if (skip) begin
				end else if (is_digit(c)) begin
					sum = value_accum * 32'd10 + 32'(c - CH_ZERO);
					value_accum = (sum > lim) ? lim[15:0] : sum[15:0];
					have_digits = 1'b1;
				end else if (c == CH_STAR) begin
					if (have_digits) begin
						r = ST_BAD_SUBFIELD;
					end else begin
						spec_field = (spec_field == SF_WIDTH) ? SF_WSTAR : SF_NONE;
						clear_value();
					end
				end else if (spec_field == SF_LEFT && (c == CH_PLUS || c == CH_MINUS)) begin
					if (have_digits) begin
						r = ST_BAD_SUBFIELD;
					end else begin
						value_negative = (c == CH_MINUS);
						have_digits = 1'b1;
					end
				end else if (spec_field == SF_EXP && c == CH_PLUS) begin
					if (have_digits)
						r = ST_BAD_SUBFIELD;
				end else if (c == CH_NUL) begin
					r = ST_PREMATURE_END;
				end else begin
					spec_field = SF_NONE;
					clear_value();
					at_top = 1'b1;
					busy = 1'b1;
				end
			end
		end
		if (r != NO_STATUS)
			spec_phase = PH_DONE;
		return r;
	endfunction

	task automatic report_mismatch(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	task automatic send_char(input logic [7:0] c, input logic sos);
		int r;
		while ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		ch <= c;
		start_of_string <= sos;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		if (sos || spec_phase != PH_DONE)
			parsed_chars++;
		r = parse_char(c, sos);
		if (r != NO_STATUS)
			expected_status_q.push_back(3'(r));
	endtask

	task automatic send_spec(input logic sos_first);
		foreach (spec_chars[i])
			send_char(spec_chars[i], sos_first && i == 0);
	endtask

	task automatic push_digits(input int unsigned n);
		repeat (n)
			spec_chars.push_back(CH_ZERO + 8'($urandom_range(9)));
	endtask

	task automatic build_random_spec();
		int unsigned pick;
		int unsigned pos;
		logic [7:0]  opener;
		logic [7:0]  noise;
		spec_chars.delete();
		repeat ($urandom_range(3)) begin
			case ($urandom_range(8))
			0: spec_chars.push_back(CH_PLUS);
			1: spec_chars.push_back(CH_MINUS);
			2: spec_chars.push_back(CH_HASH);
			3: spec_chars.push_back(CH_ZERO);
			4: spec_chars.push_back(CH_SPACE);
			5: spec_chars.push_back(CH_BANG);
			6: spec_chars.push_back(CH_COMMA);
			7: spec_chars.push_back(CH_AT);
			default: begin
				spec_chars.push_back(CH_AMP);
				spec_chars.push_back(8'($urandom_range(126, 32)));
			end
			endcase
		end
		case ($urandom_range(3))
		0: begin
		end
		1: push_digits($urandom_range(5, 1));
		2: spec_chars.push_back(CH_STAR);
		default: begin
			spec_chars.push_back(CH_STAR);
			spec_chars.push_back(CH_PLUS);
		end
		endcase
		repeat ($urandom_range(3)) begin
			case ($urandom_range(4))
			0: opener = CH_DOT;
			1: opener = CH_SEMI;
			2: opener = CH_CARET;
			3: opener = CH_TILDE;
			default: opener = CH_QUEST;
			endcase
			spec_chars.push_back(opener);
			if (opener == CH_SEMI && $urandom_range(1) == 1) begin
				spec_chars.push_back($urandom_range(1) == 1 ? CH_PLUS : CH_MINUS);
				push_digits($urandom_range(3));
			end else begin
				if (opener == CH_CARET) begin
					case ($urandom_range(2))
					0: spec_chars.push_back(CH_LOWS);
					1: spec_chars.push_back(CH_LOWA);
					default: begin
					end
					endcase
					repeat ($urandom_range(2))
						spec_chars.push_back(CH_PLUS);
				end
				if ($urandom_range(3) == 0)
					spec_chars.push_back(CH_STAR);
				else
					push_digits($urandom_range(4));
			end
		end
		case ($urandom_range(4))
		0: spec_chars.push_back(CH_LOWF);
		1: spec_chars.push_back(CH_LOWG);
		2: spec_chars.push_back(CH_UPPG);
		3: spec_chars.push_back(CH_LOWE);
		default: spec_chars.push_back(CH_UPPE);
		endcase
		// corrupt a minority of strings
		pick = $urandom_range(99);
		pos = $urandom_range(spec_chars.size() - 1);
		case ($urandom_range(5))
		0: noise = CH_NUL;
		1: noise = CH_STAR;
		2: noise = CH_PLUS;
		3: noise = CH_MINUS;
		4: noise = CH_ZERO + 8'($urandom_range(9));
		default: noise = 8'($urandom_range(255));
		endcase
		if (pick < 12)
			spec_chars[pos] = 8'($urandom_range(255));
		else if (pick < 22)
			spec_chars.insert(pos, noise);
		else if (pick < 28)
			spec_chars[spec_chars.size() - 1] = CH_NUL;
		if ($urandom_range(9) == 0) begin
			repeat ($urandom_range(3, 1))
				spec_chars.push_back(8'($urandom_range(255)));
		end
	endtask

	task automatic test_fill_char();
		spec_chars = {CH_AMP, CH_NUL};
		send_spec(1'b1);
		spec_chars = {CH_AMP, CH_LOW_CTRL};
		send_spec(1'b1);
		spec_chars = {CH_AMP, CH_DEL};
		send_spec(1'b1);
		spec_chars = {CH_AMP, CH_TILDE, CH_TOP};
		send_spec(1'b1);
	endtask

	task automatic test_premature_end();
		spec_chars = {CH_NUL};
		send_spec(1'b1);
		spec_chars = {CH_SEMI, CH_MINUS, CH_ZERO + 8'd7, CH_NUL};
		send_spec(1'b1);
		spec_chars = {CH_STAR, CH_NUL};
		send_spec(1'b1);
	endtask

	task automatic test_bad_subfield();
		spec_chars = {CH_ZERO + 8'd5, CH_STAR};
		send_spec(1'b1);
		spec_chars = {CH_SEMI, CH_PLUS, CH_MINUS};
		send_spec(1'b1);
		spec_chars = {CH_CARET, CH_ZERO + 8'd3, CH_PLUS};
		send_spec(1'b1);
	endtask

	task automatic test_misplaced_width();
		spec_chars = {CH_STAR, CH_PLUS, CH_ZERO + 8'd5};
		send_spec(1'b1);
	endtask

	task automatic test_saturation();
		spec_chars = {CH_NINE, CH_NINE, CH_NINE, CH_NINE, CH_LOWF};
		send_spec(1'b1);
		// drop: ignored until the next string start
		send_char(CH_LOWA, 1'b0);
	endtask

	task automatic test_random(input int target, input int unsigned tx_pct,
		input int unsigned rx_pct);
		int stop_at;
		tx_idle_pct = tx_pct;
		rx_idle_pct = rx_pct;
		stop_at = parsed_chars + target;
		while (parsed_chars < stop_at) begin
			build_random_spec();
			send_spec($urandom_range(19) != 0);
		end
	endtask

	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= rx_idle_pct);

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			if (expected_status_q.size() == 0) begin
				report_mismatch($sformatf("status %0d with no transaction pending", status));
			end else begin
				want_status = expected_status_q.pop_front();
				if (status !== want_status)
					report_mismatch($sformatf("status %0d, want %0d", status, want_status));
			end
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
	end

	initial begin
		do
			@(posedge clk);
		while (stall_cycles < STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	initial begin
		reset_parser();
		repeat (2)
			@(posedge clk);
		arst_n <= 1'b1;
		test_fill_char();
		test_premature_end();
		test_bad_subfield();
		test_misplaced_width();
		test_saturation();
		test_random(375, 20, 87);
		test_random(375, 87, 20);
		test_random(375, 0, 0);
		in_valid <= 1'b0;
		while (expected_status_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
